[rtl/hbp_pkg.sv]
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants for the Huffman bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int PART_W    = 7;
    localparam int WORK_W    = PART_W + CODE_W;
    localparam int TOT_W     = 6;
    localparam int PEND_W    = 3;

    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = 1;
    localparam int Q_CW      = 2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_in_run;
        logic       end_of_stream;
    } t_result;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } t_cmd;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } t_entry;

endpackage

[rtl/hbp_front.sv]
// ----------------------------------------------------------------------------
// hbp_front
// Accepts request items, drops ones with no effect, saturates code lengths
// and queues the resulting commands for the packer.
// ----------------------------------------------------------------------------
module hbp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  hbp_pkg::t_item i_item,
    output logic          o_cmd_valid,
    output hbp_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);

    localparam int EFF_LEN = (MAX_CODE_LEN < hbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                              : hbp_pkg::CODE_W;

    hbp_pkg::t_cmd                 r_q [hbp_pkg::Q_DEPTH];
    logic [hbp_pkg::Q_AW-1:0]      r_wp;
    logic [hbp_pkg::Q_AW-1:0]      r_rp;
    logic [hbp_pkg::Q_CW-1:0]      r_cnt;

    logic                          in_range;
    logic                          keep;
    logic                          wr;
    logic                          rd;
    hbp_pkg::t_cmd                 cmd;

    assign full     = (r_cnt == hbp_pkg::Q_CW'(hbp_pkg::Q_DEPTH));
    assign in_range = ({1'b0, i_item.symbol} < 9'(SYMBOL_COUNT));

    always_comb begin
        cmd.kind      = i_item.req_type;
        cmd.symbol    = i_item.symbol;
        cmd.code_bits = i_item.code_value;
        cmd.code_len  = (i_item.code_length > hbp_pkg::LEN_W'(EFF_LEN))
                        ? hbp_pkg::LEN_W'(EFF_LEN) : i_item.code_length;
        case (i_item.req_type)
            hbp_pkg::REQ_LOAD:   keep = in_range;
            hbp_pkg::REQ_ENCODE: keep = in_range;
            hbp_pkg::REQ_FINISH: keep = 1'b1;
            default:             keep = 1'b0;
        endcase
    end

    assign wr          = push && !full && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign rd          = o_cmd_valid && i_cmd_take;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + hbp_pkg::Q_CW'(wr) - hbp_pkg::Q_CW'(rd);
        end
    end

endmodule

[rtl/hbp_back.sv]
// ----------------------------------------------------------------------------
// hbp_back
// Code table and byte packer: applies loads, looks up codes and emits the
// completed bytes and the padded finish tail one per cycle unless i_out_full.
// ----------------------------------------------------------------------------
module hbp_back #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  hbp_pkg::t_cmd    i_cmd,
    output logic             o_cmd_take,
    input  logic             i_out_full,
    output logic             o_out_push,
    output hbp_pkg::t_result o_out_res
);

    localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    hbp_pkg::t_entry                   r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]           r_vld;
    hbp_pkg::t_entry                   r_rd;
    logic                              r_rd_vld;

    logic [1:0]                        r_state;
    logic [1:0]                        n_state;
    logic                              r_fin;
    logic [hbp_pkg::WORK_W-1:0]        r_work;
    logic [hbp_pkg::WORK_W-1:0]        n_work;
    logic [hbp_pkg::TOT_W-1:0]         r_tot;
    logic [hbp_pkg::TOT_W-1:0]         n_tot;
    logic [hbp_pkg::PART_W-1:0]        r_part;
    logic [hbp_pkg::PART_W-1:0]        n_part;
    logic [hbp_pkg::PEND_W-1:0]        r_pend;
    logic [hbp_pkg::PEND_W-1:0]        n_pend;

    logic [AW-1:0]                     addr;
    logic                              wr;
    logic [hbp_pkg::LEN_W-1:0]         eff_len;
    logic [hbp_pkg::CODE_W-1:0]        eff_bits;
    logic [hbp_pkg::CODE_W-1:0]        code_la;
    logic [hbp_pkg::WORK_W-1:0]        work;
    logic [hbp_pkg::TOT_W-1:0]         tot;

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign addr       = (i_cmd.kind == hbp_pkg::REQ_FINISH) ? '0 : i_cmd.symbol[AW-1:0];
    assign wr         = o_cmd_take && (i_cmd.kind == hbp_pkg::REQ_LOAD);

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[addr] <= {i_cmd.code_bits, i_cmd.code_len};
        end
        if (o_cmd_take) begin
            r_rd <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr) begin
                r_vld[addr] <= 1'b1;
            end
            if (o_cmd_take) begin
                r_rd_vld <= r_vld[addr];
            end
        end
    end

    // left-align pending bits and code into one work word
    always_comb begin
        eff_len  = r_rd_vld ? r_rd.code_len : '0;
        eff_bits = r_rd_vld ? r_rd.code_bits : '0;
        code_la  = (eff_len == '0) ? '0
                   : (eff_bits << (hbp_pkg::LEN_W'(hbp_pkg::CODE_W) - eff_len));
        work     = {r_part, {hbp_pkg::CODE_W{1'b0}}}
                   | ({code_la, {hbp_pkg::PART_W{1'b0}}} >> r_pend);
        tot      = hbp_pkg::TOT_W'(r_pend) + hbp_pkg::TOT_W'(eff_len);
    end

    always_comb begin
        n_state    = r_state;
        n_work     = r_work;
        n_tot      = r_tot;
        n_part     = r_part;
        n_pend     = r_pend;
        o_out_push = 1'b0;
        o_out_res  = '0;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_take && (i_cmd.kind != hbp_pkg::REQ_LOAD)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_work  = work;
                n_tot   = tot;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_tot >= hbp_pkg::TOT_W'(8)) begin
                    o_out_res.out_byte = r_work[hbp_pkg::WORK_W-1 -: 8];
                    if (r_fin) begin
                        o_out_res.last_in_run   = (r_tot == hbp_pkg::TOT_W'(8));
                        o_out_res.end_of_stream = (r_tot == hbp_pkg::TOT_W'(8));
                    end else begin
                        o_out_res.last_in_run   = (r_tot < hbp_pkg::TOT_W'(16));
                    end
                    if (!i_out_full) begin
                        o_out_push = 1'b1;
                        n_work     = r_work << 8;
                        n_tot      = r_tot - hbp_pkg::TOT_W'(8);
                    end
                end else if (r_fin && (r_tot != '0)) begin
                    o_out_res.out_byte      = {r_work[hbp_pkg::WORK_W-1 -: hbp_pkg::PART_W],
                                               1'b0};
                    o_out_res.last_in_run   = 1'b1;
                    o_out_res.end_of_stream = 1'b1;
                    if (!i_out_full) begin
                        o_out_push = 1'b1;
                        n_part     = '0;
                        n_pend     = '0;
                        n_tot      = '0;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_part  = r_work[hbp_pkg::WORK_W-1 -: hbp_pkg::PART_W];
                    n_pend  = r_tot[hbp_pkg::PEND_W-1:0];
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        if (o_cmd_take) begin
            r_fin <= (i_cmd.kind == hbp_pkg::REQ_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tot   <= '0;
            r_part  <= '0;
            r_pend  <= '0;
        end else begin
            r_state <= n_state;
            r_tot   <= n_tot;
            r_part  <= n_part;
            r_pend  <= n_pend;
        end
    end

    a_push_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (r_state == S_EMIT))
        else $error("byte transfer outside emit state");

    a_eos_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_out_res.end_of_stream) |-> o_out_res.last_in_run)
        else $error("end of stream without last flag");

    a_finish_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_fin && (n_state == S_IDLE)) |=> (r_pend == '0))
        else $error("packer not empty after finish");

    a_tot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_tot <= hbp_pkg::TOT_W'(hbp_pkg::WORK_W)))
        else $error("bit count exceeds work word");

endmodule

[rtl/hbp_outq.sv]
// ----------------------------------------------------------------------------
// hbp_outq
// Two-entry result queue between the packer and the output port.
// ----------------------------------------------------------------------------
module hbp_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hbp_pkg::t_result i_res,
    output logic             o_full,
    output logic             empty,
    input  logic             pop,
    output hbp_pkg::t_result o_result
);

    hbp_pkg::t_result          r_q [hbp_pkg::Q_DEPTH];
    logic [hbp_pkg::Q_AW-1:0]  r_wp;
    logic [hbp_pkg::Q_AW-1:0]  r_rp;
    logic [hbp_pkg::Q_CW-1:0]  r_cnt;
    logic                      wr;
    logic                      rd;

    assign o_full   = (r_cnt == hbp_pkg::Q_CW'(hbp_pkg::Q_DEPTH));
    assign empty    = (r_cnt == '0);
    assign o_result = r_q[r_rp];
    assign wr       = i_push && !o_full;
    assign rd       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + hbp_pkg::Q_CW'(wr) - hbp_pkg::Q_CW'(rd);
        end
    end

endmodule

[rtl/huffman_bit_packer_top.sv]
// A result byte passes the request queue, the table read register, the work register and
//   the result queue on its way to the result ports.
// A load leaves the packer idle; an encode or finish passes the table read and the work
//   register, emits one byte per cycle while the result queue has room, then returns to idle.
// Requests queue two deep ahead of the packer, results two deep behind it.
// Reset (synchronous, active low) clears all code lengths, the partial byte and queues.
// ----------------------------------------------------------------------------
// huffman_bit_packer_top
// Huffman encoder with a loadable code table and an MSB-first byte packer.
// ----------------------------------------------------------------------------
module huffman_bit_packer_top #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  hbp_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output hbp_pkg::t_result o_result
);

    logic             cmd_valid;
    hbp_pkg::t_cmd    cmd;
    logic             cmd_take;
    logic             out_full;
    logic             out_push;
    hbp_pkg::t_result out_res;

    hbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    hbp_back #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_res   (out_res)
    );

    hbp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (out_push),
        .i_res    (out_res),
        .o_full   (out_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule

[dv/huffman_bit_packer_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_bit_packer_top_test
// Self-checking bench for the Huffman bit packer. Loads code table entries,
// encodes symbols and finishes streams through the request queue, predicts
// the packed bytes and their flags, and checks every byte popped from the
// result queue. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module huffman_bit_packer_top_test;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         CODE_LIMIT  = 32;
    localparam int         SYM_COUNT   = 256;
    localparam int         LONG_HOLD   = 80;
    localparam int         STALL_LIMIT = 2000;
    localparam int         TAIL_CYCLES = 40;
    localparam int         PHASE_ITEMS = 104;

    class packer_scoreboard;
        logic [hbp_pkg::CODE_W-1:0] code_bits [SYM_COUNT];
        logic [hbp_pkg::LEN_W-1:0]  code_len  [SYM_COUNT];
        logic [7:0]                 acc;
        int unsigned                acc_cnt;
        hbp_pkg::t_result           batch[$];
        hbp_pkg::t_result           expected_bytes[$];
        int unsigned                n_bad;
        int unsigned                n_checked;
        int unsigned                n_loads;
        int unsigned                n_encodes;
        int unsigned                n_finishes;

        function new();
            foreach (code_len[i]) begin
                code_bits[i] = '0;
                code_len[i]  = '0;
            end
            acc        = '0;
            acc_cnt    = 0;
            n_bad      = 0;
            n_checked  = 0;
            n_loads    = 0;
            n_encodes  = 0;
            n_finishes = 0;
        endfunction

        function void append_code(int unsigned sym);
            hbp_pkg::t_result r;
            if (sym >= SYM_COUNT) return;
            for (int i = int'(code_len[sym]) - 1; i >= 0; i--) begin
                acc = {acc[6:0], code_bits[sym][i]};
                acc_cnt++;
                if (acc_cnt == 8) begin
                    r.out_byte      = acc;
                    r.last_in_run   = 1'b0;
                    r.end_of_stream = 1'b0;
                    batch.push_back(r);
                    acc     = '0;
                    acc_cnt = 0;
                end
            end
        endfunction

        function void note_item(hbp_pkg::t_item it);
            hbp_pkg::t_result          r;
            logic [hbp_pkg::LEN_W-1:0] len;
            batch.delete();
            case (it.req_type)
                hbp_pkg::REQ_LOAD: begin
                    n_loads++;
                    len = it.code_length;
                    if (len > CODE_LIMIT) len = hbp_pkg::LEN_W'(CODE_LIMIT);
                    if (it.symbol < SYM_COUNT) begin
                        code_bits[it.symbol] = it.code_value;
                        code_len[it.symbol]  = len;
                    end
                end
                hbp_pkg::REQ_ENCODE: begin
                    n_encodes++;
                    append_code(it.symbol);
                    if (batch.size() > 0) batch[batch.size()-1].last_in_run = 1'b1;
                end
                hbp_pkg::REQ_FINISH: begin
                    n_finishes++;
                    append_code(0);
                    if (acc_cnt > 0) begin
                        r.out_byte      = acc << (8 - acc_cnt);
                        r.last_in_run   = 1'b0;
                        r.end_of_stream = 1'b0;
                        batch.push_back(r);
                        acc     = '0;
                        acc_cnt = 0;
                    end
                    if (batch.size() > 0) begin
                        batch[batch.size()-1].last_in_run   = 1'b1;
                        batch[batch.size()-1].end_of_stream = 1'b1;
                    end
                end
                default: ;
            endcase
            foreach (batch[i]) expected_bytes.push_back(batch[i]);
        endfunction

        function void check_result(hbp_pkg::t_result got);
            hbp_pkg::t_result exp_r;
            n_checked++;
            if (expected_bytes.size() == 0) begin
                if (n_bad < 10)
                    $display("%0t: unexpected byte %02h last=%0b eos=%0b", $realtime,
                             got.out_byte, got.last_in_run, got.end_of_stream);
                n_bad++;
                return;
            end
            exp_r = expected_bytes.pop_front();
            if (got.out_byte !== exp_r.out_byte || got.last_in_run !== exp_r.last_in_run ||
                got.end_of_stream !== exp_r.end_of_stream) begin
                if (n_bad < 10)
                    $display("%0t: byte #%0d exp %02h/%0b/%0b got %02h/%0b/%0b (byte/last/eos)",
                             $realtime, n_checked, exp_r.out_byte, exp_r.last_in_run,
                             exp_r.end_of_stream, got.out_byte, got.last_in_run,
                             got.end_of_stream);
                n_bad++;
            end
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    hbp_pkg::t_item   i_item;
    logic             empty;
    logic             pop;
    hbp_pkg::t_result o_result;

    packer_scoreboard sb;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int unsigned n_eos;
    logic [7:0]  hot_sym [16];

    huffman_bit_packer_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic hbp_pkg::t_item mk(logic [1:0] req, logic [7:0] sym, logic [31:0] val,
                                          logic [5:0] len);
        hbp_pkg::t_item it;
        it.req_type    = req;
        it.symbol      = sym;
        it.code_value  = val;
        it.code_length = len;
        return it;
    endfunction

    function automatic hbp_pkg::t_item random_item();
        hbp_pkg::t_item it;
        int unsigned    pick;
        int unsigned    len_pick;
        pick           = $urandom_range(99);
        it.symbol      = ($urandom_range(9) == 0) ? 8'($urandom) : hot_sym[$urandom_range(15)];
        it.code_value  = $urandom;
        it.code_length = 6'($urandom);
        if (pick < 18) begin
            it.req_type = hbp_pkg::REQ_LOAD;
            len_pick    = $urandom_range(19);
            if (len_pick == 0)      it.code_length = '0;
            else if (len_pick == 1) it.code_length = 6'($urandom_range(63, 33));
            else if (len_pick == 2) it.code_length = 6'd32;
            else                    it.code_length = 6'($urandom_range(16, 1));
        end else if (pick < 26) begin
            it.req_type = hbp_pkg::REQ_FINISH;
        end else if (pick < 29) begin
            it.req_type = REQ_UNKNOWN;
        end else begin
            it.req_type = hbp_pkg::REQ_ENCODE;
        end
        return it;
    endfunction

    task automatic send_item(input hbp_pkg::t_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // result side: one transfer check per edge, then the next pop decision
    initial begin
        int hold_left;
        hold_left = 0;
        pop       = 1'b0;
        n_eos     = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                sb.check_result(o_result);
                if (o_result.end_of_stream) n_eos++;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles, %0d bytes still due",
                 STALL_LIMIT, sb.outstanding());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_item      = '0;
        hold_req    = 1'b0;
        tx_idle_pct = 19;
        rx_idle_pct = 46;
        hot_sym[0]  = 8'h00;
        for (int i = 1; i < 16; i++) hot_sym[i] = 8'($urandom);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty finish, zero-length code, unknown request, extremes,
        // saturated lengths, flush-only finish, five-byte finish
        send_item(mk(hbp_pkg::REQ_FINISH,  8'h00, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_ENCODE,  8'h05, 32'h0, 6'd0));
        send_item(mk(REQ_UNKNOWN,          8'hFF, 32'hFFFF_FFFF, 6'h3F));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'h00, 32'h0000_0016, 6'd5));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'hFF, 32'hFFFF_FFFF, 6'd32));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'h01, 32'hA5C3_0F96, 6'd63));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'h02, 32'h0000_0001, 6'd33));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'h03, 32'h0000_0001, 6'd1));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'h04, 32'h0000_0000, 6'd8));
        send_item(mk(hbp_pkg::REQ_ENCODE,  8'hFF, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_ENCODE,  8'h03, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_ENCODE,  8'h01, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_ENCODE,  8'h02, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_ENCODE,  8'h04, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_FINISH,  8'h00, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_FINISH,  8'h00, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'h00, 32'hFFFF_FFFF, 6'd0));
        send_item(mk(hbp_pkg::REQ_ENCODE,  8'h03, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_FINISH,  8'h00, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_FINISH,  8'h00, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'h00, 32'hDEAD_BEEF, 6'd32));
        send_item(mk(hbp_pkg::REQ_LOAD,    8'h06, 32'h0000_0055, 6'd7));
        send_item(mk(hbp_pkg::REQ_ENCODE,  8'h06, 32'h0, 6'd0));
        send_item(mk(hbp_pkg::REQ_FINISH,  8'h00, 32'h0, 6'd0));
        drain();

        for (int i = 0; i < 16; i++)
            send_item(mk(hbp_pkg::REQ_LOAD, hot_sym[i], $urandom,
                         6'($urandom_range(16, 1))));
        for (int i = 0; i < PHASE_ITEMS - 16; i++) send_item(random_item());
        drain();

        tx_idle_pct = 46;
        rx_idle_pct = 19;
        hold_req    = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Requests: %0d loads, %0d encodes, %0d finishes; bytes checked: %0d",
                 sb.n_loads, sb.n_encodes, sb.n_finishes, sb.n_checked);
        $display("Streams closed: %0d; mismatches: %0d; bytes never seen: %0d",
                 n_eos, sb.n_bad, sb.outstanding());
        if (sb.n_bad == 0 && sb.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[files.f]
rtl/hbp_pkg.sv
rtl/hbp_front.sv
rtl/hbp_back.sv
rtl/hbp_outq.sv
rtl/huffman_bit_packer_top.sv
dv/huffman_bit_packer_top_test.sv
